// ===== rtl/ikc_pkg.sv =====
// Shared types, codes and helper functions of the index key collator.
`default_nettype none

package ikc_pkg;

   // Sizes
   localparam int MAX_KEY_ELEMENTS = 256;
   localparam int ELEM_W           = 16;
   localparam int BYTE_W           = 8;
   localparam int ACTION_W         = 3;
   localparam int RULE_W           = 3;
   localparam int VALUE_BYTES      = 8;
   localparam int VCNT_W           = 4;
   localparam int NUM_W            = VALUE_BYTES * BYTE_W;

   // Action codes of an input word
   typedef logic [ACTION_W-1:0] action_type;
   localparam action_type ACT_ENTRY_KEY   = 3'd0;
   localparam action_type ACT_PROBE_KEY   = 3'd1;
   localparam action_type ACT_ENTRY_VALUE = 3'd2;
   localparam action_type ACT_PROBE_VALUE = 3'd3;
   localparam action_type ACT_COMPARE     = 3'd4;

   // Collation rule codes
   typedef logic [RULE_W-1:0] rule_type;
   localparam rule_type RULE_BINARY  = 3'd0;
   localparam rule_type RULE_ANSI    = 3'd1;
   localparam rule_type RULE_UNICODE = 3'd2;
   localparam rule_type RULE_U64     = 3'd3;
   localparam rule_type RULE_EXTENT  = 3'd4;

   // Three-way order codes
   typedef logic signed [1:0] order_type;
   localparam order_type ORDER_LT = -2'sd1;
   localparam order_type ORDER_EQ = 2'sd0;
   localparam order_type ORDER_GT = 2'sd1;

   // Character constants for case folding
   localparam logic [ELEM_W-1:0] CHAR_LOWER_A = 16'h0061;
   localparam logic [ELEM_W-1:0] CHAR_LOWER_Z = 16'h007A;
   localparam logic [ELEM_W-1:0] CASE_OFFSET  = 16'h0020;

   typedef struct packed {
      action_type        action;
      logic [ELEM_W-1:0] element;
   } req_type;

   typedef struct packed {
      order_type order;
      logic      rule_error;
      logic      overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STRIP,
      ST_LENCHK,
      ST_WALK,
      ST_NUMBER,
      ST_DONE
   } state_type;

   // Per-cycle control of the digit unit
   typedef struct packed {
      logic clear;
      logic num_step;
      logic wide;
      logic fold;
      logic extent;
      logic values_present;
   } step_type;

   // Upper-case ASCII a..z only
   function automatic logic [ELEM_W-1:0] fold_case(input logic [ELEM_W-1:0] c);
      logic [ELEM_W-1:0] r;
      r = c;
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         r = c - CASE_OFFSET;
      end
      return r;
   endfunction

   function automatic order_type cmp_elem(input logic [ELEM_W-1:0] a,
                                          input logic [ELEM_W-1:0] b);
      order_type r;
      r = ORDER_EQ;
      if (a > b) begin
         r = ORDER_GT;
      end else if (a < b) begin
         r = ORDER_LT;
      end
      return r;
   endfunction

   // Fold one byte into an LSB-first running comparison
   function automatic order_type serial_rel(input order_type rel,
                                            input logic [BYTE_W-1:0] a,
                                            input logic [BYTE_W-1:0] b);
      order_type r;
      r = rel;
      if (a > b) begin
         r = ORDER_GT;
      end else if (a < b) begin
         r = ORDER_LT;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ikc_key_store.sv =====
// Key element memory with fill count for one side of the comparison.
`default_nettype none

module ikc_key_store #(
   parameter int DEPTH = ikc_pkg::MAX_KEY_ELEMENTS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   input  wire logic [ikc_pkg::ELEM_W-1:0]    push_elem,
   input  wire logic                          clear,
   input  wire logic [$clog2(DEPTH+1)-1:0]    rd_addr,
   output logic      [ikc_pkg::ELEM_W-1:0]    rd_elem,
   output logic      [$clog2(DEPTH+1)-1:0]    count,
   output logic                               full
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);

   logic [ikc_pkg::ELEM_W-1:0] mem [DEPTH];
   logic [ikc_pkg::ELEM_W-1:0] rd_elem_ff;
   logic [CW-1:0]              count_ff;

   assign full    = (count_ff == CW'(DEPTH));
   assign count   = count_ff;
   assign rd_elem = rd_elem_ff;

   // Append at the fill count, drop once full
   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem[count_ff[AW-1:0]] <= push_elem;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      rd_elem_ff <= mem[rd_addr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         count_ff <= '0;
      end else if (push && !full) begin
         count_ff <= count_ff + CW'(1);
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ikc_digit_unit.sv =====
// Element compare and byte-serial number and extent arithmetic.
`default_nettype none

module ikc_digit_unit (
   input  wire logic                          clock,
   input  wire ikc_pkg::step_type             step,
   input  wire logic [ikc_pkg::ELEM_W-1:0]    e_elem,
   input  wire logic [ikc_pkg::ELEM_W-1:0]    p_elem,
   input  wire logic [ikc_pkg::BYTE_W-1:0]    e_byte,
   input  wire logic [ikc_pkg::BYTE_W-1:0]    p_byte,
   input  wire logic [ikc_pkg::BYTE_W-1:0]    e_len_byte,
   input  wire logic [ikc_pkg::BYTE_W-1:0]    p_len_byte,
   output ikc_pkg::order_type                 elem_order,
   output ikc_pkg::order_type                 num_order
);

   localparam int BW = ikc_pkg::BYTE_W;

   logic [ikc_pkg::ELEM_W-1:0] e_masked;
   logic [ikc_pkg::ELEM_W-1:0] p_masked;
   logic [BW:0]                sum1;
   logic [BW:0]                sum2;

   // Running relations, LSB first: a1 vs a2, a1 vs e2, e1 vs a2
   ikc_pkg::order_type rel_a_ff;
   ikc_pkg::order_type rel_a_e2_ff;
   ikc_pkg::order_type rel_e1_a2_ff;
   logic               c1_ff;
   logic               c2_ff;

   // Mask to the rule's element width, fold case for string rules
   always_comb begin
      e_masked = step.wide ? e_elem : {{BW{1'b0}}, e_elem[BW-1:0]};
      p_masked = step.wide ? p_elem : {{BW{1'b0}}, p_elem[BW-1:0]};
      if (step.fold) begin
         e_masked = ikc_pkg::fold_case(e_masked);
         p_masked = ikc_pkg::fold_case(p_masked);
      end
      elem_order = ikc_pkg::cmp_elem(e_masked, p_masked);
   end

   // One byte of each range end: e1 = a1 + len1, e2 = a2 + len2
   assign sum1 = {1'b0, e_byte} + {1'b0, e_len_byte} + {{BW{1'b0}}, c1_ff};
   assign sum2 = {1'b0, p_byte} + {1'b0, p_len_byte} + {{BW{1'b0}}, c2_ff};

   always_ff @(posedge clock) begin
      if (step.clear) begin
         rel_a_ff     <= ikc_pkg::ORDER_EQ;
         rel_a_e2_ff  <= ikc_pkg::ORDER_EQ;
         rel_e1_a2_ff <= ikc_pkg::ORDER_EQ;
         c1_ff        <= 1'b0;
         c2_ff        <= 1'b0;
      end else if (step.num_step) begin
         rel_a_ff     <= ikc_pkg::serial_rel(rel_a_ff, e_byte, p_byte);
         rel_a_e2_ff  <= ikc_pkg::serial_rel(rel_a_e2_ff, e_byte, sum2[BW-1:0]);
         rel_e1_a2_ff <= ikc_pkg::serial_rel(rel_e1_a2_ff, sum1[BW-1:0], p_byte);
         c1_ff        <= sum1[BW];
         c2_ff        <= sum2[BW];
      end
   end

   // Resolve the number order once all bytes are in
   always_comb begin
      num_order = rel_a_ff;
      if (step.extent && step.values_present) begin
         if (!c2_ff && rel_a_e2_ff != ikc_pkg::ORDER_LT) begin
            num_order = ikc_pkg::ORDER_GT;
         end else if (!c1_ff && rel_e1_a2_ff != ikc_pkg::ORDER_GT) begin
            num_order = ikc_pkg::ORDER_LT;
         end else begin
            num_order = ikc_pkg::ORDER_EQ;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/index_key_collator_core.sv =====
// Top level of the index key collator: load path, compare sequencer, result register.
//
//  channel | direction | word                          | handshake
//  req_    | in        | action, element               | req_valid / req_ready
//  rsp_    | out       | order, rule_error, overflow   | rsp_valid / rsp_ready
//  csr_    | in        | rule code                     | csr_valid / csr_ready (always ready)
//
//  Load words are taken while the sequencer is idle, also while a result waits.
//  A compare walks both key memories, one element per memory per cycle with a
//  registered read: string rules walk up to the shorter key, binary first strips
//  leading zero bytes, u64 and extent walk the eight value bytes.
//  An invalid rule answers without a walk. A compare waits while a result is held.
//  Reset is synchronous and active high; key memories are not cleared.
`default_nettype none

module index_key_collator_core #(
   parameter int MAX_KEY_ELEMENTS = ikc_pkg::MAX_KEY_ELEMENTS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire ikc_pkg::req_type             req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output ikc_pkg::rsp_type                  rsp_data,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [ikc_pkg::RULE_W-1:0]   csr_data
);

   localparam int CW = $clog2(MAX_KEY_ELEMENTS + 1);
   localparam int BW = ikc_pkg::BYTE_W;
   localparam int VW = ikc_pkg::VCNT_W;
   localparam int NW = ikc_pkg::NUM_W;

   ikc_pkg::state_type state_ff, state_in;

   ikc_pkg::rule_type  rule_ff;
   logic               rsp_valid_ff;
   ikc_pkg::rsp_type   rsp_data_ff;
   logic               overflow_ff;
   logic [VW-1:0]      e_vcnt_ff, p_vcnt_ff;
   logic [NW-1:0]      e_len_ff, p_len_ff;
   logic               rv_ff;
   logic               e_done_ff, p_done_ff;
   logic [CW-1:0]      e_ptr_ff, p_ptr_ff;
   logic [CW-1:0]      e_rpos_ff, p_rpos_ff;
   logic [CW-1:0]      e_start_ff, p_start_ff;
   logic [CW-1:0]      k_ff, walk_len_ff;
   ikc_pkg::order_type tie_ff, order_ff;

   logic               accept, cmp_go;
   logic               e_push, p_push, ev_push, pv_push;
   logic [ikc_pkg::ELEM_W-1:0] e_rd, p_rd;
   logic [CW-1:0]      e_count, p_count;
   logic               e_full, p_full;
   logic               e_vfull, p_vfull;
   logic               e_hit, p_hit;
   logic [CW-1:0]      e_rest, p_rest, min_count;
   ikc_pkg::order_type cnt_order, rest_order, elem_order, num_order;
   logic [BW-1:0]      e_byte, p_byte;
   logic               num_rule;
   ikc_pkg::step_type  step;

   // FSM outputs
   logic issue, num_step, finish, strip_on, walk_done;

   // Input decode
   assign accept    = req_valid && req_ready;
   assign cmp_go    = accept && (req_data.action == ikc_pkg::ACT_COMPARE);
   assign e_push    = accept && (req_data.action == ikc_pkg::ACT_ENTRY_KEY);
   assign p_push    = accept && (req_data.action == ikc_pkg::ACT_PROBE_KEY);
   assign ev_push   = accept && (req_data.action == ikc_pkg::ACT_ENTRY_VALUE);
   assign pv_push   = accept && (req_data.action == ikc_pkg::ACT_PROBE_VALUE);
   assign req_ready = (state_ff == ikc_pkg::ST_IDLE) &&
                      (!rsp_valid_ff || req_data.action != ikc_pkg::ACT_COMPARE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign num_rule = (rule_ff == ikc_pkg::RULE_U64) || (rule_ff == ikc_pkg::RULE_EXTENT);
   assign e_vfull  = (e_vcnt_ff == VW'(ikc_pkg::VALUE_BYTES));
   assign p_vfull  = (p_vcnt_ff == VW'(ikc_pkg::VALUE_BYTES));

   ikc_key_store #(.DEPTH(MAX_KEY_ELEMENTS)) u_entry (
      .clock     (clock),
      .reset     (reset),
      .push      (e_push),
      .push_elem (req_data.element),
      .clear     (finish),
      .rd_addr   (e_ptr_ff),
      .rd_elem   (e_rd),
      .count     (e_count),
      .full      (e_full)
   );

   ikc_key_store #(.DEPTH(MAX_KEY_ELEMENTS)) u_probe (
      .clock     (clock),
      .reset     (reset),
      .push      (p_push),
      .push_elem (req_data.element),
      .clear     (finish),
      .rd_addr   (p_ptr_ff),
      .rd_elem   (p_rd),
      .count     (p_count),
      .full      (p_full)
   );

   // Count compares and returned-word checks
   always_comb begin
      min_count  = (e_count < p_count) ? e_count : p_count;
      cnt_order  = (e_count > p_count) ? ikc_pkg::ORDER_GT :
                   (e_count < p_count) ? ikc_pkg::ORDER_LT : ikc_pkg::ORDER_EQ;
      e_rest     = e_count - e_start_ff;
      p_rest     = p_count - p_start_ff;
      rest_order = (e_rest > p_rest) ? ikc_pkg::ORDER_GT :
                   (e_rest < p_rest) ? ikc_pkg::ORDER_LT : ikc_pkg::ORDER_EQ;
      e_hit      = (e_rpos_ff >= e_count) || (e_rd[BW-1:0] != '0);
      p_hit      = (p_rpos_ff >= p_count) || (p_rd[BW-1:0] != '0);
      e_byte     = (e_rpos_ff < e_count) ? e_rd[BW-1:0] : '0;
      p_byte     = (p_rpos_ff < p_count) ? p_rd[BW-1:0] : '0;
   end

   always_comb begin
      step.clear          = cmp_go;
      step.num_step       = num_step;
      step.wide           = (rule_ff == ikc_pkg::RULE_UNICODE);
      step.fold           = (rule_ff == ikc_pkg::RULE_ANSI) ||
                            (rule_ff == ikc_pkg::RULE_UNICODE);
      step.extent         = (rule_ff == ikc_pkg::RULE_EXTENT);
      step.values_present = (e_vcnt_ff != '0) && (p_vcnt_ff != '0);
   end

   ikc_digit_unit u_digit (
      .clock      (clock),
      .step       (step),
      .e_elem     (e_rd),
      .p_elem     (p_rd),
      .e_byte     (e_byte),
      .p_byte     (p_byte),
      .e_len_byte (e_len_ff[BW-1:0]),
      .p_len_byte (p_len_ff[BW-1:0]),
      .elem_order (elem_order),
      .num_order  (num_order)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ikc_pkg::ST_IDLE: begin
            if (cmp_go) begin
               unique case (rule_ff) inside
                  ikc_pkg::RULE_BINARY:  state_in = ikc_pkg::ST_STRIP;
                  ikc_pkg::RULE_ANSI,
                  ikc_pkg::RULE_UNICODE: state_in = ikc_pkg::ST_WALK;
                  ikc_pkg::RULE_U64,
                  ikc_pkg::RULE_EXTENT:  state_in = ikc_pkg::ST_NUMBER;
                  default:               state_in = ikc_pkg::ST_DONE;
               endcase
            end
         end
         ikc_pkg::ST_STRIP: begin
            if (e_done_ff && p_done_ff) begin
               state_in = ikc_pkg::ST_LENCHK;
            end
         end
         ikc_pkg::ST_LENCHK: begin
            state_in = (rest_order != ikc_pkg::ORDER_EQ) ? ikc_pkg::ST_DONE
                                                         : ikc_pkg::ST_WALK;
         end
         ikc_pkg::ST_WALK: begin
            if ((rv_ff && elem_order != ikc_pkg::ORDER_EQ) || walk_done) begin
               state_in = ikc_pkg::ST_DONE;
            end
         end
         ikc_pkg::ST_NUMBER: begin
            if (walk_done) begin
               state_in = ikc_pkg::ST_DONE;
            end
         end
         ikc_pkg::ST_DONE: state_in = ikc_pkg::ST_IDLE;
         default:          state_in = ikc_pkg::ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      issue     = 1'b0;
      num_step  = 1'b0;
      finish    = 1'b0;
      strip_on  = 1'b0;
      walk_done = (k_ff == walk_len_ff) && !rv_ff;
      unique case (state_ff)
         ikc_pkg::ST_STRIP: begin
            issue    = 1'b1;
            strip_on = 1'b1;
         end
         ikc_pkg::ST_WALK: begin
            issue = (k_ff < walk_len_ff);
         end
         ikc_pkg::ST_NUMBER: begin
            issue    = (k_ff < walk_len_ff);
            num_step = rv_ff;
         end
         ikc_pkg::ST_DONE: finish = 1'b1;
         default: ;
      endcase
   end

   // Control registers, value registers and result handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ikc_pkg::ST_IDLE;
         rule_ff      <= ikc_pkg::RULE_BINARY;
         rsp_valid_ff <= 1'b0;
         overflow_ff  <= 1'b0;
         e_vcnt_ff    <= '0;
         p_vcnt_ff    <= '0;
         e_len_ff     <= '0;
         p_len_ff     <= '0;
         rv_ff        <= 1'b0;
         e_done_ff    <= 1'b0;
         p_done_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= issue;

         if (csr_valid && csr_ready) begin
            rule_ff <= csr_data;
         end

         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         // Mark words dropped for lack of room
         if (finish) begin
            overflow_ff <= 1'b0;
         end else if ((e_push && e_full) || (p_push && p_full) ||
                      (ev_push && e_vfull) || (pv_push && p_vfull)) begin
            overflow_ff <= 1'b1;
         end

         // Value bytes: write lane on load, shift out during number walk, drop on finish
         if (finish) begin
            e_vcnt_ff <= '0;
            p_vcnt_ff <= '0;
            e_len_ff  <= '0;
            p_len_ff  <= '0;
         end else if (num_step) begin
            e_len_ff <= e_len_ff >> BW;
            p_len_ff <= p_len_ff >> BW;
         end else begin
            if (ev_push && !e_vfull) begin
               e_len_ff[{e_vcnt_ff[VW-2:0], 3'b000} +: BW] <= req_data.element[BW-1:0];
               e_vcnt_ff <= e_vcnt_ff + VW'(1);
            end
            if (pv_push && !p_vfull) begin
               p_len_ff[{p_vcnt_ff[VW-2:0], 3'b000} +: BW] <= req_data.element[BW-1:0];
               p_vcnt_ff <= p_vcnt_ff + VW'(1);
            end
         end

         // Leading-zero scan completion per side
         if (cmp_go) begin
            e_done_ff <= 1'b0;
            p_done_ff <= 1'b0;
         end else if (strip_on && rv_ff) begin
            if (!e_done_ff && e_hit) begin
               e_done_ff <= 1'b1;
            end
            if (!p_done_ff && p_hit) begin
               p_done_ff <= 1'b1;
            end
         end
      end
   end

   // Read pointers, walk counters and order
   always_ff @(posedge clock) begin
      e_rpos_ff <= e_ptr_ff;
      p_rpos_ff <= p_ptr_ff;

      if (cmp_go) begin
         e_ptr_ff    <= '0;
         p_ptr_ff    <= '0;
         k_ff        <= '0;
         walk_len_ff <= num_rule ? CW'(ikc_pkg::VALUE_BYTES) : min_count;
         tie_ff      <= cnt_order;
         order_ff    <= ikc_pkg::ORDER_EQ;
      end else begin
         unique case (state_ff)
            ikc_pkg::ST_STRIP: begin
               if (e_ptr_ff < e_count && !e_done_ff) begin
                  e_ptr_ff <= e_ptr_ff + CW'(1);
               end
               if (p_ptr_ff < p_count && !p_done_ff) begin
                  p_ptr_ff <= p_ptr_ff + CW'(1);
               end
               if (rv_ff && !e_done_ff && e_hit) begin
                  e_start_ff <= e_rpos_ff;
               end
               if (rv_ff && !p_done_ff && p_hit) begin
                  p_start_ff <= p_rpos_ff;
               end
            end
            ikc_pkg::ST_LENCHK: begin
               e_ptr_ff    <= e_start_ff;
               p_ptr_ff    <= p_start_ff;
               k_ff        <= '0;
               walk_len_ff <= e_rest;
               tie_ff      <= ikc_pkg::ORDER_EQ;
               order_ff    <= rest_order;
            end
            ikc_pkg::ST_WALK: begin
               if (issue) begin
                  e_ptr_ff <= e_ptr_ff + CW'(1);
                  p_ptr_ff <= p_ptr_ff + CW'(1);
                  k_ff     <= k_ff + CW'(1);
               end
               if (rv_ff && elem_order != ikc_pkg::ORDER_EQ) begin
                  order_ff <= elem_order;
               end else if (walk_done) begin
                  order_ff <= tie_ff;
               end
            end
            ikc_pkg::ST_NUMBER: begin
               if (issue) begin
                  e_ptr_ff <= e_ptr_ff + CW'(1);
                  p_ptr_ff <= p_ptr_ff + CW'(1);
                  k_ff     <= k_ff + CW'(1);
               end
               if (walk_done) begin
                  order_ff <= num_order;
               end
            end
            default: ;
         endcase
      end

      // Capture the result word
      if (finish) begin
         rsp_data_ff.order      <= order_ff;
         rsp_data_ff.rule_error <= (rule_ff > ikc_pkg::RULE_EXTENT);
         rsp_data_ff.overflow   <= overflow_ff;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ikc_checker.sv =====
// Port-level checks of the index key collator, bound to the top level.
`default_nettype none

module ikc_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire ikc_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire ikc_pkg::rsp_type rsp_data
);

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // Invalid rule answers equal
   a_err_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rule_error |-> rsp_data.order == ikc_pkg::ORDER_EQ)
      else $error("rule error with nonzero order");

   // Order is one of the three codes
   a_order_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.order == ikc_pkg::ORDER_LT ||
                    rsp_data.order == ikc_pkg::ORDER_EQ ||
                    rsp_data.order == ikc_pkg::ORDER_GT)
      else $error("order code out of range");

   // A compare is taken only with no result pending, and the block then stops taking words
   a_cmp_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.action == ikc_pkg::ACT_COMPARE
      |-> !rsp_valid ##1 !req_ready)
      else $error("compare accepted while result pending or block not busy");

endmodule

bind index_key_collator_core ikc_checker u_ikc_checker (.*);

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench of index_key_collator_core: random key pairs, predicted orders.
module testbench import ikc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         PHASES        = 9;
   localparam int         PHASE_WORDS   = 18;
   localparam int         SETTLE_CYCLES = 32;
   localparam action_type ACT_SPARE_LO  = 3'd5;
   localparam action_type ACT_SPARE_HI  = 3'd7;
   localparam rule_type   RULE_BAD_LO   = 3'd5;
   localparam rule_type   RULE_BAD_HI   = 3'd7;

   typedef req_type word_list[$];

   logic     clock     = 1'b0;
   logic     reset     = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   req_type  req_data  = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   rsp_type  rsp_data;
   logic     csr_valid = 1'b0;
   logic     csr_ready;
   rule_type csr_data  = RULE_BINARY;

   // Stimulus and expectation stores
   req_type pending_words[$];
   rsp_type verdicts[$];
   int      issued      = 0;
   int      fault_count = 0;
   int      send_gap    = 0;
   int      hold_cycles = 0;
   bit      calm        = 1'b0;

   // Shadow state of the collator
   logic [ELEM_W-1:0] entry_key [MAX_KEY_ELEMENTS];
   logic [ELEM_W-1:0] probe_key [MAX_KEY_ELEMENTS];
   int                entry_len    = 0;
   int                probe_len    = 0;
   int                entry_vbytes = 0;
   int                probe_vbytes = 0;
   logic [NUM_W-1:0]  entry_span   = '0;
   logic [NUM_W-1:0]  probe_span   = '0;
   bit                spill        = 1'b0;
   rule_type          active_rule  = RULE_BINARY;

   index_key_collator_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic order_type rank(input logic [NUM_W-1:0] a, input logic [NUM_W-1:0] b);
      return (a > b) ? ORDER_GT : ((a < b) ? ORDER_LT : ORDER_EQ);
   endfunction

   function automatic logic [ELEM_W-1:0] upper(input logic [ELEM_W-1:0] c);
      return (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ? c - CASE_OFFSET : c;
   endfunction

   // Little-endian number from the first eight key bytes
   function automatic logic [NUM_W-1:0] key_value(input bit probe);
      logic [NUM_W-1:0] v;
      v = '0;
      for (int k = 0; k < VALUE_BYTES; k++) begin
         if (k < (probe ? probe_len : entry_len)) begin
            v[8*k +: 8] = probe ? probe_key[k][7:0] : entry_key[k][7:0];
         end
      end
      return v;
   endfunction

   function automatic order_type binary_order();
      int        i;
      int        j;
      int        n;
      int        m;
      order_type r;
      i = 0;
      j = 0;
      while (i < entry_len && entry_key[i][7:0] == 8'h00) i++;
      while (j < probe_len && probe_key[j][7:0] == 8'h00) j++;
      n = entry_len - i;
      m = probe_len - j;
      if (n != m) begin
         return rank(n, m);
      end
      for (int k = 0; k < n; k++) begin
         r = rank(entry_key[i+k][7:0], probe_key[j+k][7:0]);
         if (r != ORDER_EQ) return r;
      end
      return ORDER_EQ;
   endfunction

   function automatic order_type text_order(input bit wide);
      logic [ELEM_W-1:0] a;
      logic [ELEM_W-1:0] b;
      order_type         r;
      for (int k = 0; k < entry_len && k < probe_len; k++) begin
         a = wide ? entry_key[k] : {8'h00, entry_key[k][7:0]};
         b = wide ? probe_key[k] : {8'h00, probe_key[k][7:0]};
         r = rank(upper(a), upper(b));
         if (r != ORDER_EQ) return r;
      end
      return rank(entry_len, probe_len);
   endfunction

   // Ranges overlap gives equal; range ends carry into bit 64
   function automatic order_type extent_order();
      logic [NUM_W-1:0] a1;
      logic [NUM_W-1:0] a2;
      logic [NUM_W:0]   e1;
      logic [NUM_W:0]   e2;
      a1 = key_value(1'b0);
      a2 = key_value(1'b1);
      if (entry_vbytes == 0 || probe_vbytes == 0) begin
         return rank(a1, a2);
      end
      e2 = {1'b0, a2} + {1'b0, probe_span};
      if (!e2[NUM_W] && a1 >= e2[NUM_W-1:0]) return ORDER_GT;
      e1 = {1'b0, a1} + {1'b0, entry_span};
      if (!e1[NUM_W] && e1[NUM_W-1:0] <= a2) return ORDER_LT;
      return ORDER_EQ;
   endfunction

   // Apply one accepted word to the shadow state
   task automatic collate_word(input req_type w);
      rsp_type v;
      case (w.action)
         ACT_ENTRY_KEY: begin
            if (entry_len < MAX_KEY_ELEMENTS) begin
               entry_key[entry_len] = w.element;
               entry_len++;
            end else begin
               spill = 1'b1;
            end
         end
         ACT_PROBE_KEY: begin
            if (probe_len < MAX_KEY_ELEMENTS) begin
               probe_key[probe_len] = w.element;
               probe_len++;
            end else begin
               spill = 1'b1;
            end
         end
         ACT_ENTRY_VALUE: begin
            if (entry_vbytes < VALUE_BYTES) begin
               entry_span[8*entry_vbytes +: 8] = w.element[7:0];
               entry_vbytes++;
            end else begin
               spill = 1'b1;
            end
         end
         ACT_PROBE_VALUE: begin
            if (probe_vbytes < VALUE_BYTES) begin
               probe_span[8*probe_vbytes +: 8] = w.element[7:0];
               probe_vbytes++;
            end else begin
               spill = 1'b1;
            end
         end
         ACT_COMPARE: begin
            v.rule_error = 1'b0;
            v.overflow   = spill;
            case (active_rule)
               RULE_BINARY:  v.order = binary_order();
               RULE_ANSI:    v.order = text_order(1'b0);
               RULE_UNICODE: v.order = text_order(1'b1);
               RULE_U64:     v.order = rank(key_value(1'b0), key_value(1'b1));
               RULE_EXTENT:  v.order = extent_order();
               default: begin
                  v.order      = ORDER_EQ;
                  v.rule_error = 1'b1;
               end
            endcase
            verdicts.push_back(v);
            // Start a fresh pair
            entry_len    = 0;
            probe_len    = 0;
            entry_vbytes = 0;
            probe_vbytes = 0;
            entry_span   = '0;
            probe_span   = '0;
            spill        = 1'b0;
         end
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic req_type make_word(input action_type a, input logic [ELEM_W-1:0] e);
      req_type w;
      w.action  = a;
      w.element = e;
      return w;
   endfunction

   task automatic post(input req_type w);
      pending_words.push_back(w);
      if (w.action <= ACT_COMPARE) issued++;
   endtask

   function automatic logic [ELEM_W-1:0] pick_char();
      logic [ELEM_W-1:0] raw;
      raw = ELEM_W'($urandom);
      case ($urandom_range(0, 7))
         0: return CHAR_LOWER_A + ELEM_W'($urandom_range(0, 25));
         1: return CHAR_LOWER_A - CASE_OFFSET + ELEM_W'($urandom_range(0, 25));
         2: begin
            case ($urandom_range(0, 3))
               0:       return CHAR_LOWER_A - ELEM_W'(1);
               1:       return CHAR_LOWER_Z + ELEM_W'(1);
               2:       return CHAR_LOWER_A - CASE_OFFSET - ELEM_W'(1);
               default: return CHAR_LOWER_Z - CASE_OFFSET + ELEM_W'(1);
            endcase
         end
         3: return {raw[15:8], 8'h00};
         4: return {8'h00, raw[7:0]};
         5: return {raw[15:8], CHAR_LOWER_A[7:0] + 8'($urandom_range(0, 25))};
         6: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: return raw;
      endcase
   endfunction

   function automatic logic [NUM_W-1:0] pick_number();
      case ($urandom_range(0, 2))
         0:       return NUM_W'($urandom_range(0, 60));
         1:       return {$urandom, $urandom};
         default: return ~NUM_W'(0) - NUM_W'($urandom_range(0, 60));
      endcase
   endfunction

   function automatic logic [NUM_W-1:0] pick_span();
      case ($urandom_range(0, 3))
         0:       return NUM_W'($urandom_range(0, 1));
         1, 2:    return NUM_W'($urandom_range(1, 40));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Byte count of a key or value, past eight now and then
   function automatic int pick_count();
      case ($urandom_range(0, 9))
         0:          return 0;
         1:          return $urandom_range(9, 10);
         2, 3, 4, 5: return VALUE_BYTES;
         default:    return $urandom_range(1, 7);
      endcase
   endfunction

   function automatic word_list byte_words(input action_type a, input logic [NUM_W-1:0] num,
                                           input int nb);
      word_list          q;
      logic [ELEM_W-1:0] e;
      for (int k = 0; k < nb; k++) begin
         e = ELEM_W'($urandom);
         if (k < VALUE_BYTES) e[7:0] = num[8*k +: 8];
         q.push_back(make_word(a, e));
      end
      return q;
   endfunction

   // One entry/probe pair with its loads interleaved, then mostly a compare
   task automatic queue_pair(input rule_type r);
      word_list         ek;
      word_list         pk;
      word_list         ev;
      word_list         pv;
      logic [NUM_W-1:0] a1;
      logic [NUM_W-1:0] a2;
      logic [NUM_W-1:0] n1;
      logic [NUM_W-1:0] n2;
      logic [ELEM_W-1:0] c;
      int               len;
      bit               numeric;
      numeric = (r == RULE_U64 || r == RULE_EXTENT) ? ($urandom_range(0, 5) != 0)
                                                    : ($urandom_range(0, 5) == 0);
      if (numeric) begin
         n1 = pick_span();
         n2 = pick_span();
         a1 = pick_number();
         case ($urandom_range(0, 5))
            0:       a2 = a1;
            1:       a2 = a1 + n1;
            2:       a2 = a1 - n2;
            3:       a2 = a1 + NUM_W'($urandom_range(0, 40)) - NUM_W'(20);
            default: a2 = pick_number();
         endcase
         ek = byte_words(ACT_ENTRY_KEY, a1, pick_count());
         pk = byte_words(ACT_PROBE_KEY, a2, pick_count());
         ev = byte_words(ACT_ENTRY_VALUE, n1, pick_count());
         pv = byte_words(ACT_PROBE_VALUE, n2, pick_count());
      end else begin
         len = $urandom_range(0, 8);
         repeat (len) ek.push_back(make_word(ACT_ENTRY_KEY, pick_char()));
         if ($urandom_range(0, 1)) begin
            // Probe derived from the entry: case flips, one-off edits, length change
            foreach (ek[k]) begin
               c = ek[k].element;
               case ($urandom_range(0, 7))
                  0:       c = c ^ CASE_OFFSET;
                  1:       c = pick_char();
                  default: ;
               endcase
               pk.push_back(make_word(ACT_PROBE_KEY, c));
            end
            case ($urandom_range(0, 3))
               0:       if (pk.size() > 0) void'(pk.pop_back());
               1:       pk.push_back(make_word(ACT_PROBE_KEY, pick_char()));
               default: ;
            endcase
         end else begin
            len = $urandom_range(0, 8);
            repeat (len) pk.push_back(make_word(ACT_PROBE_KEY, pick_char()));
         end
         if (r == RULE_BINARY) begin
            repeat ($urandom_range(0, 3)) ek.push_front(make_word(ACT_ENTRY_KEY, {8'($urandom), 8'h00}));
            repeat ($urandom_range(0, 3)) pk.push_front(make_word(ACT_PROBE_KEY, {8'($urandom), 8'h00}));
         end
         if ($urandom_range(0, 3) == 0) ev = byte_words(ACT_ENTRY_VALUE, pick_span(), pick_count());
         if ($urandom_range(0, 3) == 0) pv = byte_words(ACT_PROBE_VALUE, pick_span(), pick_count());
      end
      // Interleave the four streams, keeping order within each
      while (ek.size() + pk.size() + ev.size() + pv.size() > 0) begin
         case ($urandom_range(0, 3))
            0:       if (ek.size() > 0) post(ek.pop_front());
            1:       if (pk.size() > 0) post(pk.pop_front());
            2:       if (ev.size() > 0) post(ev.pop_front());
            default: if (pv.size() > 0) post(pv.pop_front());
         endcase
         if ($urandom_range(0, 19) == 0) begin
            post(make_word(action_type'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)),
                           ELEM_W'($urandom)));
         end
      end
      // Now and then drop the compare so the next pair piles on
      if ($urandom_range(0, 19) != 0) post(make_word(ACT_COMPARE, ELEM_W'($urandom)));
   endtask

   // Full-depth keys: entry may run past the store, probe walks to the last element
   task automatic queue_long_pair();
      logic [ELEM_W-1:0] body [MAX_KEY_ELEMENTS];
      int                extra;
      extra = $urandom_range(0, 3);
      for (int k = 0; k < MAX_KEY_ELEMENTS; k++) begin
         body[k] = {8'($urandom), 8'($urandom_range(1, 255))};
      end
      for (int k = 0; k < MAX_KEY_ELEMENTS + extra; k++) begin
         post(make_word(ACT_ENTRY_KEY, (k < MAX_KEY_ELEMENTS) ? body[k] : ELEM_W'($urandom)));
      end
      if ($urandom_range(0, 1)) body[$urandom_range(200, MAX_KEY_ELEMENTS-1)] = ELEM_W'($urandom);
      for (int k = 0; k < MAX_KEY_ELEMENTS; k++) post(make_word(ACT_PROBE_KEY, body[k]));
      post(make_word(ACT_COMPARE, ELEM_W'($urandom)));
   endtask

   task automatic write_rule(input rule_type r);
      csr_valid <= 1'b1;
      csr_data  <= r;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      active_rule = r;
   endtask

   // Wait until every word is taken and every result has come back
   task automatic settle();
      do @(posedge clock); while (pending_words.size() != 0 || req_valid || verdicts.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      rule_type plan [PHASES];
      int       goal;
      plan = '{RULE_BINARY, RULE_ANSI, RULE_UNICODE, RULE_U64, RULE_EXTENT, RULE_BAD_HI,
               rule_type'($urandom_range(RULE_BAD_LO, RULE_BAD_HI - 1)), RULE_EXTENT,
               rule_type'($urandom_range(RULE_BINARY, RULE_EXTENT))};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < PHASES; p++) begin
         calm = (p == PHASES - 1);
         write_rule(plan[p]);
         if (p == 0) begin
            // Empty keys, zero-byte strip with a set high byte, value spill, spare actions
            post(make_word(ACT_COMPARE, 16'h0000));
            post(make_word(ACT_ENTRY_KEY, 16'h0000));
            post(make_word(ACT_ENTRY_KEY, 16'hFF00));
            post(make_word(ACT_ENTRY_KEY, 16'hFFFF));
            post(make_word(ACT_PROBE_KEY, 16'h00FF));
            post(make_word(ACT_COMPARE, 16'hFFFF));
            repeat (VALUE_BYTES + 1) post(make_word(ACT_ENTRY_VALUE, 16'hFFFF));
            post(make_word(ACT_PROBE_VALUE, 16'h0000));
            post(make_word(ACT_PROBE_KEY, 16'h0000));
            post(make_word(ACT_COMPARE, 16'h0000));
            post(make_word(ACT_SPARE_LO, 16'hFFFF));
            post(make_word(ACT_SPARE_HI, 16'h0000));
         end
         if (plan[p] == RULE_UNICODE) queue_long_pair();
         goal = issued + PHASE_WORDS;
         while (issued < goal) queue_pair(plan[p]);
         post(make_word(ACT_COMPARE, ELEM_W'($urandom)));
         settle();
      end
      if (fault_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- driver

   // Hold each word until taken, then fetch the next after an optional gap
   always @(posedge clock) begin
      logic    next_valid;
      req_type next_word;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         next_word  = req_data;
         if (req_valid && req_ready) begin
            collate_word(req_data);
            next_valid = 1'b0;
            if (!calm && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 9);
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_words.size() > 0) begin
               next_word  = pending_words.pop_front();
               next_valid = 1'b1;
            end
         end
         req_valid <= next_valid;
         req_data  <= next_word;
      end
   end

   // ---------------------------------------------------------------- monitor

   // Check each taken result word against the oldest verdict, stall in bursts
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (verdicts.size() == 0) begin
               $error("unexpected result word %p", rsp_data);
               fault_count++;
            end else begin
               want = verdicts.pop_front();
               if (rsp_data.order !== want.order) begin
                  $error("order: expected %0d, got %0d", want.order, rsp_data.order);
                  fault_count++;
               end
               if (rsp_data.rule_error !== want.rule_error) begin
                  $error("rule_error: expected %0b, got %0b", want.rule_error, rsp_data.rule_error);
                  fault_count++;
               end
               if (rsp_data.overflow !== want.overflow) begin
                  $error("overflow: expected %0b, got %0b", want.overflow, rsp_data.overflow);
                  fault_count++;
               end
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) hold_cycles = $urandom_range(1, 9);
         end
      end
   end

endmodule

// ===== index_key_collator_core.f =====
rtl/ikc_pkg.sv
rtl/ikc_key_store.sv
rtl/ikc_digit_unit.sv
rtl/index_key_collator_core.sv
rtl/ikc_checker.sv
dv/testbench.sv
